@@ hdl/ptc_pkg.sv @@
// Package with shared widths, state encoding and control structs for the triple counter.
`timescale 1ns / 1ps

package ptc_pkg;

    localparam int BOUND_W = 16;
    localparam int COUNT_W = 16;
    localparam int M_W     = 8;
    localparam int N_W     = 9;
    localparam int SQ_W    = 17;
    localparam int H_W     = 18;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OUTER,
        S_INNER,
        S_GCD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic init_n;
        logic step_n;
        logic step_m;
        logic gcd_load;
        logic gcd_step;
        logic count_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic range_ok;
        logic m_in;
        logic n_in;
        logic h_in;
        logic gcd_done;
        logic gcd_one;
        logic out_free;
    } t_status;

endpackage

@@ hdl/ptc_datapath.sv @@
// Datapath of the triple counter: index walk, incremental squares, binary gcd, count and output.
`timescale 1ns / 1ps

module ptc_datapath import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [BOUND_W-1:0] i_range_begin,
    input  logic [BOUND_W-1:0] i_range_end,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [COUNT_W-1:0] o_triple_count
);

    logic [BOUND_W-1:0] r_lo;
    logic [BOUND_W-1:0] r_hi;
    logic [M_W-1:0]     r_m;
    logic [SQ_W-1:0]    r_m_sq;
    logic [N_W-1:0]     r_n;
    logic [SQ_W-1:0]    r_n_sq;
    logic [M_W-1:0]     r_gcd_a;
    logic [M_W-1:0]     r_gcd_b;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic [H_W-1:0]     w_h;

    assign w_h = H_W'(r_m_sq) + H_W'(r_n_sq);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo <= i_range_begin;
            r_hi <= i_range_end;
            r_m <= M_W'(2);
            r_m_sq <= SQ_W'(4);
        end else if (i_cmd.step_m) begin
            r_m <= r_m + M_W'(1);
            r_m_sq <= r_m_sq + SQ_W'({r_m, 1'b1});
        end

        if (i_cmd.init_n) begin
            if (r_m[0] == 1'b0) begin
                r_n <= N_W'(1);
                r_n_sq <= SQ_W'(1);
            end else begin
                r_n <= N_W'(2);
                r_n_sq <= SQ_W'(4);
            end
        end else if (i_cmd.step_n) begin
            r_n <= r_n + N_W'(2);
            r_n_sq <= r_n_sq + SQ_W'({r_n, 2'b00}) + SQ_W'(4);
        end

        if (i_cmd.gcd_load) begin
            r_gcd_a <= r_m;
            r_gcd_b <= r_n[M_W-1:0];
        end else if (i_cmd.gcd_step) begin
            if (!r_gcd_a[0] || !r_gcd_b[0]) begin
                if (!r_gcd_a[0]) begin
                    r_gcd_a <= r_gcd_a >> 1;
                end
                if (!r_gcd_b[0]) begin
                    r_gcd_b <= r_gcd_b >> 1;
                end
            end else if (r_gcd_a > r_gcd_b) begin
                r_gcd_a <= (r_gcd_a - r_gcd_b) >> 1;
            end else begin
                r_gcd_b <= (r_gcd_b - r_gcd_a) >> 1;
            end
        end

        if (i_cmd.out_load) begin
            r_out_count <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.count_inc && (r_count != '1)) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.range_ok = (i_range_end > i_range_begin);
        o_status.m_in     = (r_m_sq < SQ_W'(r_hi));
        o_status.n_in     = (r_n < N_W'(r_m));
        o_status.h_in     = (w_h >= H_W'(r_lo)) && (w_h < H_W'(r_hi));
        o_status.gcd_done = (r_gcd_a == r_gcd_b);
        o_status.gcd_one  = (r_gcd_a == M_W'(1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_triple_count = r_out_count;

endmodule

@@ hdl/ptc_ctrl.sv @@
// Controller state machine that sequences the walk over m, n and the gcd test.
`timescale 1ns / 1ps

module ptc_ctrl import ptc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.range_ok ? S_OUTER : S_DONE;
                end
            end
            S_OUTER: begin
                if (i_status.m_in) begin
                    o_cmd.init_n = 1'b1;
                    n_state = S_INNER;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INNER: begin
                if (!i_status.n_in) begin
                    o_cmd.step_m = 1'b1;
                    n_state = S_OUTER;
                end else if (i_status.h_in) begin
                    o_cmd.gcd_load = 1'b1;
                    n_state = S_GCD;
                end else begin
                    o_cmd.step_n = 1'b1;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.count_inc = i_status.gcd_one;
                    o_cmd.step_n = 1'b1;
                    n_state = S_INNER;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/primitive_triple_counter.sv @@
// Top level of the primitive Pythagorean triple counter.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-------------------------------
//   input   | in        | i_in_valid / o_in_ready    | i_range_begin, i_range_end
//   output  | out       | o_out_valid / i_out_ready  | o_triple_count
//
// One item is worked at a time. For each m with m*m below the end, the single pair walker
// steps n over the pairs of that m, and each pair whose sum of squares lies in the range runs
// the binary gcd loop; an empty range goes straight to the done state. The gcd step loop and
// the pair walker set how long an item takes.
// Reset is synchronous and active low; it clears the controller, the running count and the output valid flag.
// A new beat is taken while a finished count waits in the output register; a stalled output
// holds the next count in the done state until the register frees.
`timescale 1ns / 1ps

module primitive_triple_counter import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [BOUND_W-1:0] i_range_begin,
    input  logic [BOUND_W-1:0] i_range_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COUNT_W-1:0] o_triple_count
);

    t_cmd    w_cmd;
    t_status w_status;

    ptc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ptc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_range_begin  (i_range_begin),
        .i_range_end    (i_range_end),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_triple_count (o_triple_count)
    );

endmodule

@@ hdl/ptc_checker.sv @@
// Port-level checker for the triple counter, bound to the top level.
`timescale 1ns / 1ps

module ptc_checker import ptc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [BOUND_W-1:0] i_range_begin,
    input logic [BOUND_W-1:0] i_range_end,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COUNT_W-1:0] o_triple_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output beat dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_triple_count))
        else $error("Output count changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input taken again while an item is in progress.");

    a_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid && (i_range_end <= i_range_begin)
        |-> ##2 (o_out_valid && (o_triple_count == '0)))
        else $error("Empty range did not give a zero count in time.");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("Block not idle after reset.");

endmodule

bind primitive_triple_counter ptc_checker u_ptc_checker (.*);

@@ tb/sv/primitive_triple_counter_test.sv @@
// Self-checking testbench for the primitive Pythagorean triple counter.
`timescale 1ns / 1ps

import ptc_pkg::*;

class triple_count_board;
    logic [COUNT_W-1:0] expected_counts[$];
    int unsigned        mismatches;

    function new();
        mismatches = 0;
    endfunction

    function logic [COUNT_W-1:0] count_triples(logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi);
        int unsigned total;
        int unsigned m;
        int unsigned n;
        int unsigned hyp;
        int unsigned a;
        int unsigned b;
        int unsigned r;
        total = 0;
        if (hi > lo) begin
            for (m = 2; m * m < hi; m++) begin
                for (n = (m % 2 == 0) ? 1 : 2; n < m; n += 2) begin
                    hyp = m * m + n * n;
                    if (hyp >= lo && hyp < hi) begin
                        a = m;
                        b = n;
                        while (b != 0) begin
                            r = a % b;
                            a = b;
                            b = r;
                        end
                        if (a == 1 && total < 32'hFFFF) begin
                            total++;
                        end
                    end
                end
            end
        end
        return total[COUNT_W-1:0];
    endfunction

    function void note_range(logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi);
        expected_counts.push_back(count_triples(lo, hi));
    endfunction

    function void check_count(logic [COUNT_W-1:0] actual);
        logic [COUNT_W-1:0] wanted;
        if (expected_counts.size() == 0) begin
            $display("%0t: count beat with nothing expected, expected none actual %0d",
                     $time, actual);
            mismatches++;
        end else begin
            wanted = expected_counts.pop_front();
            if (actual !== wanted) begin
                $display("%0t: triple_count mismatch, expected %0d actual %0d",
                         $time, wanted, actual);
                mismatches++;
            end
        end
    endfunction

    function int unsigned pending();
        return expected_counts.size();
    endfunction
endclass

module primitive_triple_counter_test;

    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned RANDOM_ITEMS = 100;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [BOUND_W-1:0] i_range_begin;
    logic [BOUND_W-1:0] i_range_end;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COUNT_W-1:0] o_triple_count;

    triple_count_board board;
    logic              hold_output;
    logic              steady_flow;
    int unsigned       cycle_count;

    primitive_triple_counter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_range_begin  (i_range_begin),
        .i_range_end    (i_range_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_triple_count (o_triple_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    task automatic send_range(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_range_begin <= lo;
        i_range_end   <= hi;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_range(lo, hi);
    endtask

    task automatic pick_range(output logic [BOUND_W-1:0] lo, output logic [BOUND_W-1:0] hi);
        int unsigned sel;
        int unsigned a;
        int unsigned b;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            b = $urandom_range(0, 1024);
            a = $urandom_range(0, b);
        end else if (sel < 65) begin
            b = $urandom_range(0, 4096);
            a = $urandom_range(0, b);
        end else if (sel < 75) begin
            a = $urandom_range(0, 65535);
            b = a + $urandom_range(0, 512);
            if (b > 65535) begin
                b = 65535;
            end
        end else begin
            a = $urandom_range(0, 65535);
            b = $urandom_range(0, 65535);
            if (b > a) begin
                sel = a;
                a = b;
                b = sel;
            end
        end
        lo = a[BOUND_W-1:0];
        hi = b[BOUND_W-1:0];
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_count(o_triple_count);
        end
    end

    initial begin
        int unsigned out_gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end
            out_gap = steady_flow ? 0 : $urandom_range(0, 6);
            if (out_gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (out_gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready) && !hold_output);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("primitive_triple_counter_test NOT OK");
        $finish;
    end

    initial begin
        int unsigned        k;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        board         = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_range_begin = '0;
        i_range_end   = '0;
        i_out_ready   = 1'b0;
        hold_output   = 1'b0;
        steady_flow   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_range(16'd0, 16'd0);
        send_range(16'd0, 16'd1);
        send_range(16'd1, 16'd2);
        send_range(16'd0, 16'd5);
        send_range(16'd5, 16'd6);
        send_range(16'd0, 16'd6);
        send_range(16'd25, 16'd26);
        send_range(16'd45, 16'd46);
        send_range(16'd0, 16'd26);
        send_range(16'd0, 16'd100);
        send_range(16'd2, 16'd300);
        send_range(16'd1000, 16'd1200);
        send_range(16'd100, 16'd50);
        send_range(16'hFFFF, 16'hFFFF);
        send_range(16'hFFFF, 16'h0000);
        send_range(16'hAAAA, 16'h5555);
        send_range(16'h5555, 16'h5655);
        send_range(16'hFFFE, 16'hFFFF);
        send_range(16'd65000, 16'hFFFF);
        send_range(16'h0000, 16'hFFFF);

        // Output stalls for a long stretch while small ranges keep arriving.
        hold_output = 1'b1;
        for (k = 0; k < 8; k++) begin
            send_range(BOUND_W'($urandom_range(0, 20)), BOUND_W'($urandom_range(0, 40)));
        end
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            steady_flow = (k >= 30 && k < 50);
            pick_range(lo, hi);
            send_range(lo, hi);
        end
        steady_flow = 1'b0;
        i_in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("primitive_triple_counter_test OK");
        end else begin
            $display("primitive_triple_counter_test NOT OK");
        end
        $finish;
    end

endmodule
